/* src/length_prefixed_packet_deframer_defines.svh */
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH

// Assertion checked at every clock edge outside reset.
`define LPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that also holds while reset is applied.
`define LPPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/lppd_pkg.sv */
package lppd_pkg;

  // Configuration register indexes
  localparam logic RegStartByte = 1'b0;
  localparam logic RegMaxLen    = 1'b1;

  // Event codes
  localparam logic [1:0] EvNone     = 2'd0;
  localparam logic [1:0] EvPayload  = 2'd1;
  localparam logic [1:0] EvComplete = 2'd2;
  localparam logic [1:0] EvError    = 2'd3;

  localparam logic [7:0] CheckBytes      = 8'd4;
  localparam logic [7:0] StartByteReset  = 8'd0;
  localparam logic [7:0] MaxLenReset     = 8'd255;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  packet_cmd;
    logic [7:0]  packet_len;
    logic [31:0] packet_check;
  } out_t;

  typedef struct packed {
    logic       we;
    logic       idx;
    logic [7:0] wdata;
  } cfg_t;

endpackage

/* src/lppd_fsm.sv */
module lppd_fsm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  lppd_pkg::in_t  in_i,
  input  lppd_pkg::cfg_t cfg_i,
  output lppd_pkg::out_t res_o
);

  typedef enum logic [2:0] {
    PhHunt,
    PhCmd,
    PhLen,
    PhData,
    PhCheck,
    PhComplete,
    PhError
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] check_q, check_d;
  logic [7:0]  start_q, max_len_q;
  logic [7:0]  count_inc;
  logic [31:0] check_upd;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    check_upd = check_q;
    check_upd[{count_q[1:0], 3'b000} +: 8] = in_i.rx_byte;
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    check_d = check_q;
    res_o   = '0;
    if (in_i.req_type) begin
      phase_d = PhHunt;
      count_d = '0;
    end else begin
      unique case (phase_q)
        PhHunt: begin
          if (in_i.rx_byte == start_q) phase_d = PhCmd;
        end
        PhCmd: begin
          cmd_d   = in_i.rx_byte;
          phase_d = PhLen;
        end
        PhLen: begin
          if (in_i.rx_byte > max_len_q) begin
            phase_d = PhError;
          end else begin
            len_d   = in_i.rx_byte;
            count_d = '0;
            phase_d = (in_i.rx_byte == 8'd0) ? PhCheck : PhData;
          end
        end
        PhData: begin
          res_o.event_res     = lppd_pkg::EvPayload;
          res_o.payload_byte  = in_i.rx_byte;
          res_o.payload_index = count_q;
          count_d             = count_inc;
          if (count_inc >= len_q) begin
            count_d = '0;
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          check_d = check_upd;
          count_d = count_inc;
          if (count_inc >= lppd_pkg::CheckBytes) begin
            phase_d            = PhComplete;
            res_o.event_res    = lppd_pkg::EvComplete;
            res_o.packet_cmd   = cmd_q;
            res_o.packet_len   = len_q;
            res_o.packet_check = check_upd;
          end
        end
        default: begin
          // complete or error: drop the byte and report
          res_o.event_res = lppd_pkg::EvError;
          phase_d         = PhHunt;
          count_d         = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      count_q   <= '0;
      cmd_q     <= '0;
      len_q     <= '0;
      check_q   <= '0;
      start_q   <= lppd_pkg::StartByteReset;
      max_len_q <= lppd_pkg::MaxLenReset;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        check_q <= check_d;
      end
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          lppd_pkg::RegStartByte: start_q   <= cfg_i.wdata;
          lppd_pkg::RegMaxLen:    max_len_q <= cfg_i.wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

/* src/lppd_outreg.sv */
module lppd_outreg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  lppd_pkg::out_t res_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          out_ready_i,
  output lppd_pkg::out_t data_o
);

  logic          valid_q, valid_d;
  lppd_pkg::out_t data_q;

  // free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= res_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/length_prefixed_packet_deframer.sv */
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (req_type, rx_byte)
// out       output     out_valid_o / out_ready_i  out_data_o (event and packet fields)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One result per input transaction, registered and valid in the cycle after acceptance.
// One transaction per cycle while in_ready_o is high; the only result storage is the single result register.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset: hunting for the start byte, start byte 0, maximum length 255.
module length_prefixed_packet_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lppd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lppd_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i
);

  logic           accept;
  lppd_pkg::out_t  res;
  lppd_pkg::cfg_t  cfg;

  assign accept    = in_valid_i && in_ready_o;
  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  lppd_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  lppd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data_o)
  );

endmodule

/* src/lppd_checker.sv */
`include "length_prefixed_packet_deframer_defines.svh"

module lppd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input lppd_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input lppd_pkg::out_t out_data_o,
  input logic          cfg_we_i,
  input logic          cfg_idx_i,
  input logic [7:0]    cfg_wdata_i
);

  logic in_acc;
  logic out_stall;
  logic not_payload;
  logic payload_clear;

  assign in_acc        = in_valid_i && in_ready_o;
  assign out_stall     = out_valid_o && !out_ready_i;
  assign not_payload   = out_valid_o && (out_data_o.event_res != lppd_pkg::EvPayload);
  assign payload_clear = (out_data_o.payload_byte == 8'd0) && (out_data_o.payload_index == 8'd0);

  `LPPD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")

  `LPPD_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_data_o), "held result changed")

  `LPPD_ASSERT(a_ready_rule, in_ready_o == !out_stall, "input stalled while result register free")

  `LPPD_ASSERT(a_result_follows, in_acc |=> out_valid_o, "accepted transaction gave no result")

  `LPPD_ASSERT(a_payload_fields, not_payload |-> payload_clear, "payload fields without payload event")

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (.*);

/* tb/deframe_checker.sv */
module deframe_checker
  import lppd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_t       out_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef enum logic [2:0] {
    PhHunt, PhCmd, PhLen, PhData, PhTrailer, PhDone, PhError
  } frame_phase_e;

  logic [7:0]   start_byte_q;
  logic [7:0]   max_len_q;
  frame_phase_e phase_q;
  logic [7:0]   count_q;
  logic [7:0]   cmd_q;
  logic [7:0]   len_q;
  logic [31:0]  check_q;

  out_t expected_events[$];
  out_t exp_res;
  int   mismatches;

  // advances the predicted framing state by one transaction
  function automatic out_t deframe_step(in_t item);
    out_t res;
    res = '0;
    if (item.req_type) begin
      phase_q = PhHunt;
      count_q = '0;
      return res;
    end
    case (phase_q)
      PhHunt: begin
        if (item.rx_byte == start_byte_q) phase_q = PhCmd;
      end
      PhCmd: begin
        cmd_q   = item.rx_byte;
        phase_q = PhLen;
      end
      PhLen: begin
        if (item.rx_byte > max_len_q) begin
          phase_q = PhError;
        end else begin
          len_q   = item.rx_byte;
          count_q = '0;
          phase_q = (item.rx_byte == 8'd0) ? PhTrailer : PhData;
        end
      end
      PhData: begin
        res.event_res     = EvPayload;
        res.payload_byte  = item.rx_byte;
        res.payload_index = count_q;
        count_q = count_q + 8'd1;
        if (count_q >= len_q) begin
          count_q = '0;
          phase_q = PhTrailer;
        end
      end
      PhTrailer: begin
        // trailer arrives least significant byte first
        check_q[8*count_q[1:0] +: 8] = item.rx_byte;
        count_q = count_q + 8'd1;
        if (count_q >= CheckBytes) begin
          phase_q          = PhDone;
          res.event_res    = EvComplete;
          res.packet_cmd   = cmd_q;
          res.packet_len   = len_q;
          res.packet_check = check_q;
        end
      end
      default: begin
        // byte after completion or after a bad length
        res.event_res = EvError;
        phase_q = PhHunt;
        count_q = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q = StartByteReset;
      max_len_q    = MaxLenReset;
      phase_q      = PhHunt;
      count_q      = '0;
      cmd_q        = '0;
      len_q        = '0;
      check_q      = '0;
      mismatches   = 0;
      expected_events.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          if (mismatches < 10)
            $display("deframer: result with nothing expected at %0t: %p", $time, out_data_i);
          mismatches++;
        end else begin
          exp_res = expected_events.pop_front();
          if (out_data_i.event_res     !== exp_res.event_res     ||
              out_data_i.payload_byte  !== exp_res.payload_byte  ||
              out_data_i.payload_index !== exp_res.payload_index ||
              out_data_i.packet_cmd    !== exp_res.packet_cmd    ||
              out_data_i.packet_len    !== exp_res.packet_len    ||
              out_data_i.packet_check  !== exp_res.packet_check) begin
            if (mismatches < 10)
              $display("deframer: mismatch at %0t: expected %p, got %p",
                       $time, exp_res, out_data_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_events.push_back(deframe_step(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegStartByte: start_byte_q = cfg_wdata_i;
          RegMaxLen:    max_len_q    = cfg_wdata_i;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_events.size();
    end
  end

endmodule

/* tb/tb_length_prefixed_packet_deframer.sv */
module tb_length_prefixed_packet_deframer;
  import lppd_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 48;
  localparam int SettleCycles  = 8;
  localparam int FullFrame     = 1000;
  localparam int PhaseBudget   = 35;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending;

  int         items_sent;
  int         burst_left;
  int         hold_req;
  logic [7:0] frame_start;
  logic [7:0] frame_max;

  length_prefixed_packet_deframer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  deframe_checker frame_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // gaps between bursts; valid is only lowered here or when settling
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic put(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    pace();
  endtask

  task automatic send_byte(input logic [7:0] b);
    put(in_t'{req_type: 1'b0, rx_byte: b});
  endtask

  task automatic send_release();
    put(in_t'{req_type: 1'b1, rx_byte: 8'($urandom_range(0, 255))});
  endtask

  // start, command, length, payload, trailer; stops after cut bytes
  task automatic send_frame(input logic [7:0] cmd, input int len, input int cut);
    for (int k = 0; k < len + 7 && k < cut; k++) begin
      if (k == 0) send_byte(frame_start);
      else if (k == 1) send_byte(cmd);
      else if (k == 2) send_byte(8'(len));
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] start_val, input logic [7:0] max_val);
    cfg_we    <= 1'b1;
    cfg_idx   <= RegStartByte;
    cfg_wdata <= start_val;
    @(posedge clk);
    cfg_idx   <= RegMaxLen;
    cfg_wdata <= max_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_start = start_val;
    frame_max   = max_val;
  endtask

  task automatic random_traffic(input int budget);
    int first;
    int kind;
    int cap;
    int len;
    int tail;
    first = items_sent;
    while (items_sent - first < budget) begin
      kind = $urandom_range(0, 99);
      cap  = (frame_max < 40) ? int'(frame_max) : 40;
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cap)
                                         : $urandom_range(0, (cap < 6) ? cap : 6);
      if (kind < 60) begin
        send_frame(8'($urandom_range(0, 255)), len, FullFrame);
        tail = $urandom_range(0, 9);
        if (tail < 6) send_release();
        else if (tail < 9) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 70 && frame_max < 8'd255) begin
        send_frame(8'($urandom_range(0, 255)), $urandom_range(frame_max + 1, 255), 3);
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        else send_release();
      end else if (kind < 80) begin
        // cut short by a release anywhere in the frame
        send_frame(8'($urandom_range(0, 255)), len, $urandom_range(1, len + 6));
        send_release();
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) send_byte(frame_start);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        send_release();
      end
    end
  endtask

  initial begin : receiver
    int mode;
    int left;
    int hold_served;
    int hold_left;
    mode = 0;
    left = 0;
    hold_served = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        hold_left   = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 80);
        end
        left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [7:0] phase_start [5];
    logic [7:0] phase_max [5];
    rst_n       = 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 0;
    frame_start = StartByteReset;
    frame_max   = MaxLenReset;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= RegStartByte;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored byte, release while hunting, zero length, dropped
    // byte after completion, length at the maximum, length above it
    configure(8'hA5, 8'd3);
    send_byte(8'h00);
    send_release();
    send_frame(8'hFF, 0, FullFrame);
    send_byte(8'h5A);
    send_frame(8'h00, 3, FullFrame);
    send_release();
    send_frame(8'h3C, 4, 3);
    send_byte(8'hFF);

    phase_start = '{8'h00, 8'hFF, 8'h7E, 8'($urandom_range(0, 255)), 8'h00};
    phase_max   = '{8'd255, 8'd0, 8'd16, 8'($urandom_range(0, 255)), 8'd8};
    for (int p = 0; p < 5; p++) begin
      settle();
      configure(phase_start[p], phase_max[p]);
      // long receiver stall while items keep coming
      if (p == 1 || p == 3) hold_req++;
      random_traffic(PhaseBudget);
    end

    // one frame of the largest length reaches payload index 254
    settle();
    configure(8'hC3, 8'd255);
    send_frame(8'($urandom_range(0, 255)), 255, FullFrame);
    send_release();
    random_traffic(15);

    settle();
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* length_prefixed_packet_deframer.f */
+incdir+src
src/lppd_pkg.sv
src/lppd_fsm.sv
src/lppd_outreg.sv
src/length_prefixed_packet_deframer.sv
src/lppd_checker.sv
tb/deframe_checker.sv
tb/tb_length_prefixed_packet_deframer.sv
